// ===== src/call_latency_profiler_assert.svh =====
// Assertion macros for the call latency profiler
`ifndef CALL_LATENCY_PROFILER_ASSERT_SVH
`define CALL_LATENCY_PROFILER_ASSERT_SVH
// implication checked on every clock, held off during reset
`define CLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/clp_pkg.sv =====
// Package for the call latency profiler: beat types, sizes and queue entry type
package clp_pkg;
  localparam int ThreadSlots = 256;
  localparam int CallKinds = 1024;
  localparam int TimelineDepth = 4096;
  localparam int TsW = $clog2(ThreadSlots);
  localparam int CkW = $clog2(CallKinds);
  localparam int TlW = $clog2(TimelineDepth);
  localparam int QDepth = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_END   = 1'b1
  } op_e;

  typedef struct packed {
    logic           op;
    logic           traced;
    logic [TsW-1:0] thread_slot;
    logic [CkW-1:0] call_number;
    logic [63:0]    timestamp_ns;
  } in_beat_t;

  typedef struct packed {
    logic [TsW-1:0] done_thread;
    logic [CkW-1:0] done_call;
    logic [63:0]    elapsed_ns;
    logic [63:0]    finish_ns;
    logic [TlW-1:0] timeline_slot;
    logic [31:0]    call_count;
    logic [63:0]    latency_sum;
    logic [63:0]    latency_max;
    logic [63:0]    latency_min;
    logic [63:0]    completed_total;
  } out_beat_t;

  // completed call handed from front to back
  typedef struct packed {
    logic [TsW-1:0] thread;
    logic [CkW-1:0] call;
    logic [63:0]    duration;
    logic [63:0]    finish;
  } done_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_READ,
    FS_CALC
  } front_state_e;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_READ,
    BS_CALC
  } back_state_e;
endpackage

// ===== src/call_latency_profiler.sv =====
// Top level of the call latency profiler; done strobes each result for one cycle, no stall.
// An end beat with a stored start passes front read and calc, the queue, then back read and
// calc before done goes high. Start and ignored beats are taken one per cycle; an end beat
// holds busy through read (no stored start) or read and calc (stored start, longer while the
// queue is full). The back steps idle, read, calc per result. Reset clears start valid bits and
// counters at once, then the statistics memory is zeroed while completions wait in the queue.
`include "call_latency_profiler_assert.svh"
module call_latency_profiler import clp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_beat_t  in_beat,
  output logic      busy,
  output logic      done,
  output out_beat_t result
);
  logic  q_push, q_full, q_pop, q_empty, back_idle;
  done_t q_in, q_out;

  clp_front u_front (.clk, .rst, .start, .in_beat, .busy, .q_full, .q_push, .q_data(q_in));
  clp_queue u_queue (.clk, .rst, .push(q_push), .din(q_in), .full(q_full), .pop(q_pop),
                     .empty(q_empty), .dout(q_out));
  clp_back  u_back (.clk, .rst, .q_empty, .q_data(q_out), .q_pop, .done, .result,
                    .idle(back_idle));

  `CLP_ASSERT_IMP(a_no_push_full, q_push, !q_full)
  `CLP_ASSERT_NXT(a_done_single, done, !done)
  `CLP_ASSERT_IMP(a_pop_needs_idle, q_pop, back_idle && !q_empty)
endmodule

// ===== src/clp_front.sv =====
// Front part: thread slot store, pairs start and end events
module clp_front import clp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_beat_t in_beat,
  output logic     busy,
  input  logic     q_full,
  output logic     q_push,
  output done_t    q_data
);
  logic [ThreadSlots-1:0] start_valid;
  logic [63:0]    start_time [ThreadSlots];
  logic [CkW-1:0] start_call [ThreadSlots];
  front_state_e   state, state_next;
  in_beat_t       cur;
  logic [63:0]    rd_time;
  logic [CkW-1:0] rd_call;
  logic           hit;
  logic           take;

  assign take = start && !busy;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= FS_IDLE;
    else state <= state_next;
  end

  // busy is low only in idle, so start alone qualifies the beat there
  always_comb begin
    state_next = state;
    busy = 1'b0;
    q_push = 1'b0;
    unique case (state)
      FS_IDLE: if (start && in_beat.traced && in_beat.op == OP_END) state_next = FS_READ;
      FS_READ: begin
        busy = 1'b1;
        state_next = hit ? FS_CALC : FS_IDLE;
      end
      FS_CALC: begin
        busy = 1'b1;
        if (!q_full) begin
          q_push = 1'b1;
          state_next = FS_IDLE;
        end
      end
      default: state_next = FS_IDLE;
    endcase
  end

  assign hit = start_valid[cur.thread_slot];

  // capture beat, store starts, registered read of the start entry
  always_ff @(posedge clk) begin
    if (take) cur <= in_beat;
    if (take && in_beat.traced && in_beat.op == OP_START) begin
      start_time[in_beat.thread_slot] <= in_beat.timestamp_ns;
      start_call[in_beat.thread_slot] <= in_beat.call_number;
    end
    rd_time <= start_time[cur.thread_slot];
    rd_call <= start_call[cur.thread_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) start_valid <= '0;
    else if (take && in_beat.traced && in_beat.op == OP_START)
      start_valid[in_beat.thread_slot] <= 1'b1;
    else if (state == FS_READ && hit)
      start_valid[cur.thread_slot] <= 1'b0;
  end

  // entry read in the read cycle is ready in the calc cycle
  assign q_data = '{thread: cur.thread_slot, call: rd_call,
                    duration: cur.timestamp_ns - rd_time,
                    finish: cur.timestamp_ns};
endmodule

// ===== src/clp_queue.sv =====
// Short queue between front and back
module clp_queue import clp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  done_t din,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output done_t dout
);
  done_t mem [QDepth];
  logic [$clog2(QDepth)-1:0] wp, rp;
  logic [$clog2(QDepth):0] cnt;

  assign full = cnt == ($clog2(QDepth)+1)'(QDepth);
  assign empty = cnt == '0;
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp] <= din;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) wp <= wp + 1'b1;
      if (pop && !empty) rp <= rp + 1'b1;
      cnt <= cnt + ($clog2(QDepth)+1)'(push && !full) - ($clog2(QDepth)+1)'(pop && !empty);
    end
  end
endmodule

// ===== src/clp_back.sv =====
// Back part: per-call statistics memory and result beat
module clp_back import clp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  done_t     q_data,
  output logic      q_pop,
  output logic      done,
  output out_beat_t result,
  output logic      idle
);
  // statistics memory, zeroed by a clearing pass after reset
  logic [31:0] stat_count [CallKinds];
  logic [63:0] stat_sum [CallKinds];
  logic [63:0] stat_max [CallKinds];
  logic [63:0] stat_min [CallKinds];
  back_state_e state, state_next;
  done_t       cur;
  logic [CkW-1:0] clr_idx;
  logic [31:0] rc, nc;
  logic [63:0] rs, rx, rn, ns, nx, nn;
  logic [63:0] event_index, completed_count;

  always_ff @(posedge clk) begin
    if (rst) state <= BS_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    unique case (state)
      BS_CLEAR: if (clr_idx == CkW'(CallKinds - 1)) state_next = BS_IDLE;
      BS_IDLE: if (!q_empty) begin
        q_pop = 1'b1;
        state_next = BS_READ;
      end
      BS_READ: state_next = BS_CALC;
      BS_CALC: state_next = BS_IDLE;
      default: state_next = BS_IDLE;
    endcase
  end
  assign idle = state == BS_IDLE;

  // read stage
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    rc <= stat_count[cur.call];
    rs <= stat_sum[cur.call];
    rx <= stat_max[cur.call];
    rn <= stat_min[cur.call];
  end

  // update values; a zeroed entry gives count 1 and the duration for sum, max and min
  always_comb begin
    nc = (rc == '1) ? rc : rc + 32'd1;
    ns = rs + cur.duration;
    nx = (cur.duration > rx) ? cur.duration : rx;
    nn = (rn == '0 || cur.duration < rn) ? cur.duration : rn;
  end

  // memory write: clearing pass, then one update per result
  always_ff @(posedge clk) begin
    if (state == BS_CLEAR) begin
      stat_count[clr_idx] <= '0;
      stat_sum[clr_idx] <= '0;
      stat_max[clr_idx] <= '0;
      stat_min[clr_idx] <= '0;
    end else if (state == BS_CALC) begin
      stat_count[cur.call] <= nc;
      stat_sum[cur.call] <= ns;
      stat_max[cur.call] <= nx;
      stat_min[cur.call] <= nn;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BS_CALC) begin
      result <= '{done_thread: cur.thread, done_call: cur.call,
                  elapsed_ns: cur.duration, finish_ns: cur.finish,
                  timeline_slot: event_index[TlW-1:0], call_count: nc,
                  latency_sum: ns, latency_max: nx, latency_min: nn,
                  completed_total: completed_count + 64'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      event_index <= '0;
      completed_count <= '0;
      done <= 1'b0;
    end else begin
      done <= state == BS_CALC;
      if (state == BS_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (state == BS_CALC) begin
        event_index <= event_index + 64'd1;
        completed_count <= completed_count + 64'd1;
      end
    end
  end
endmodule

// ===== sim/tb.sv =====
// Testbench for the call latency profiler: directed and random call beats checked against a predictor
module tb;
  import clp_pkg::*;

  logic      clk;
  logic      rst;
  logic      start;
  in_beat_t  in_beat;
  logic      busy;
  logic      done;
  out_beat_t result;

  call_latency_profiler dut (
    .clk(clk), .rst(rst), .start(start), .in_beat(in_beat),
    .busy(busy), .done(done), .result(result)
  );

  // predictor state
  bit          pend_valid [ThreadSlots];
  bit [63:0]   pend_time  [ThreadSlots];
  bit [9:0]    pend_call  [ThreadSlots];
  bit          kind_valid [CallKinds];
  bit [31:0]   kind_count [CallKinds];
  bit [63:0]   kind_sum   [CallKinds];
  bit [63:0]   kind_max   [CallKinds];
  bit [63:0]   kind_min   [CallKinds];
  bit [63:0]   timeline_idx;
  bit [63:0]   completions;

  out_beat_t   expected_calls[$];
  int          fail_count;
  int          done_seen;
  int          beats_sent;
  longint      cycle_count;
  localparam longint CycleLimit = 200000;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // work out the result a beat causes, if any
  function automatic void predict_call(in_beat_t b);
    out_beat_t r;
    bit [63:0] dur;
    bit [9:0]  k;
    if (!b.traced) return;
    if (op_e'(b.op) == OP_START) begin
      pend_valid[b.thread_slot] = 1'b1;
      pend_time[b.thread_slot]  = b.timestamp_ns;
      pend_call[b.thread_slot]  = b.call_number;
      return;
    end
    if (!pend_valid[b.thread_slot]) return;
    dur = b.timestamp_ns - pend_time[b.thread_slot];
    k   = pend_call[b.thread_slot];
    pend_valid[b.thread_slot] = 1'b0;
    if (kind_valid[k]) begin
      if (kind_count[k] != 32'hFFFF_FFFF) kind_count[k]++;
      kind_sum[k] += dur;
      if (dur > kind_max[k]) kind_max[k] = dur;
      if (kind_min[k] == 0 || dur < kind_min[k]) kind_min[k] = dur;
    end else begin
      kind_valid[k] = 1'b1;
      kind_count[k] = 1;
      kind_sum[k]   = dur;
      kind_max[k]   = dur;
      kind_min[k]   = dur;
    end
    r.done_thread     = b.thread_slot;
    r.done_call       = k;
    r.elapsed_ns      = dur;
    r.finish_ns       = b.timestamp_ns;
    r.timeline_slot   = timeline_idx[11:0];
    r.call_count      = kind_count[k];
    r.latency_sum     = kind_sum[k];
    r.latency_max     = kind_max[k];
    r.latency_min     = kind_min[k];
    timeline_idx++;
    completions++;
    r.completed_total = completions;
    expected_calls.push_back(r);
  endfunction

  // result checker
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst && done) begin
      done_seen++;
      if (expected_calls.size() == 0) begin
        $error("unexpected result beat for thread %0d", result.done_thread);
        fail_count++;
      end else begin
        e = expected_calls.pop_front();
        if (result !== e) begin
          fail_count++;
          if (result.done_thread !== e.done_thread)
            $error("done_thread exp %0d got %0d", e.done_thread, result.done_thread);
          if (result.done_call !== e.done_call)
            $error("done_call exp %0d got %0d", e.done_call, result.done_call);
          if (result.elapsed_ns !== e.elapsed_ns)
            $error("elapsed_ns exp %0h got %0h", e.elapsed_ns, result.elapsed_ns);
          if (result.finish_ns !== e.finish_ns)
            $error("finish_ns exp %0h got %0h", e.finish_ns, result.finish_ns);
          if (result.timeline_slot !== e.timeline_slot)
            $error("timeline_slot exp %0d got %0d", e.timeline_slot, result.timeline_slot);
          if (result.call_count !== e.call_count)
            $error("call_count exp %0d got %0d", e.call_count, result.call_count);
          if (result.latency_sum !== e.latency_sum)
            $error("latency_sum exp %0h got %0h", e.latency_sum, result.latency_sum);
          if (result.latency_max !== e.latency_max)
            $error("latency_max exp %0h got %0h", e.latency_max, result.latency_max);
          if (result.latency_min !== e.latency_min)
            $error("latency_min exp %0h got %0h", e.latency_min, result.latency_min);
          if (result.completed_total !== e.completed_total)
            $error("completed_total exp %0h got %0h", e.completed_total,
                   result.completed_total);
        end
      end
    end
  end

  // send one beat after a random gap (if gaps is set), hold until accepted
  task automatic send_call(bit op, bit traced, bit [7:0] th, bit [9:0] cn, bit [63:0] ts,
                           bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_beat <= '{op: op, traced: traced, thread_slot: th, call_number: cn, timestamp_ns: ts};
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_call('{op: op, traced: traced, thread_slot: th, call_number: cn,
                   timestamp_ns: ts});
    beats_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_calls.size() != 0) @(posedge clk);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // extremes, ignored events, overwrite, wrap, unset minimum
  task automatic test_directed();
    send_call(OP_END, 1, 8'd0, 10'd0, 64'd5);               // end with no start
    send_call(OP_START, 0, 8'd1, 10'd1, 64'd0);             // untraced start
    send_call(OP_END, 1, 8'd1, 10'd1, 64'd9);               // so nothing pending
    send_call(OP_START, 1, 8'd0, 10'd0, 64'd0);
    send_call(OP_END, 1, 8'd0, 10'd3, 64'd0);               // zero duration
    send_call(OP_START, 1, 8'd0, 10'd0, 64'd100);
    send_call(OP_END, 1, 8'd0, 10'd0, 64'd150);             // min was zero: replaced
    send_call(OP_START, 1, 8'd255, 10'd1023, 64'hFFFF_FFFF_FFFF_FFF0);
    send_call(OP_START, 1, 8'd255, 10'd1023, 64'hFFFF_FFFF_FFFF_FFFF); // overwrite
    send_call(OP_END, 0, 8'd255, 10'd0, 64'd3);             // untraced end
    send_call(OP_END, 1, 8'd255, 10'd0, 64'd3);             // wraps past 2^64
    send_call(OP_START, 1, 8'd255, 10'd1023, 64'd10);
    send_call(OP_END, 1, 8'd255, 10'd0, 64'd0);             // huge duration
    send_call(OP_START, 1, 8'd255, 10'd1023, 64'd0);
    send_call(OP_END, 1, 8'd255, 10'd512, 64'hFFFF_FFFF_FFFF_FFFF);
    send_call(OP_START, 1, 8'd170, 10'd682, 64'h5555_5555_5555_5555);
    send_call(OP_END, 1, 8'd170, 10'd341, 64'hAAAA_AAAA_AAAA_AAAA);
    send_call(OP_END, 1, 8'd170, 10'd341, 64'hAAAA_AAAA_AAAA_AAAB); // already cleared
    drain_results();
  endtask

  // random traffic: random start and end beats, mostly on few threads and calls
  task automatic test_random(int n);
    bit [7:0] th;
    bit [9:0] cn;
    for (int i = 0; i < n; i++) begin
      th = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 15));
      cn = ($urandom_range(0, 3) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 7));
      send_call(1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0, th, cn,
                ($urandom_range(0, 4) == 0) ? rand64() : 64'($urandom_range(0, 100000)),
                i % 200 < 150);
      if (i == n / 2) drain_results();  // sender pauses until everything is back
    end
    drain_results();
  endtask

  // long call: repeated updates on one call number
  task automatic test_repeat_kind();
    bit [63:0] t;
    t = rand64();
    for (int i = 0; i < 60; i++) begin
      send_call(OP_START, 1, 8'(i), 10'd7, t);
      t = t + 64'($urandom_range(0, 5000));
      send_call(OP_END, 1, 8'(i), 10'd0, t);
    end
    drain_results();
  endtask

  initial begin
    fail_count = 0; done_seen = 0; beats_sent = 0; cycle_count = 0;
    timeline_idx = 0; completions = 0;
    foreach (pend_valid[i]) pend_valid[i] = 0;
    foreach (kind_valid[i]) kind_valid[i] = 0;
    rst = 1'b1; start = 1'b0; in_beat = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_repeat_kind();
    test_random(1150);
    repeat (20) @(posedge clk);
    $display("Sent %0d beats, checked %0d completed calls (directed, repeat, random).",
             beats_sent, done_seen);
    if (fail_count == 0 && expected_calls.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/clp_pkg.sv
src/clp_front.sv
src/clp_queue.sv
src/clp_back.sv
src/call_latency_profiler.sv
sim/tb.sv
